### rtl/jacr_pkg.sv
// Shared widths, constants and types for the joystick angle change reporter.
// Used by the divider unit and the top level; depends on nothing else.
`default_nettype none

package jacr_pkg;

	localparam int DIVIDEND_W = 15;	// magnitude * 90 stays below 2**15
	localparam int DIVISOR_W  = 10;	// sum of two 8-bit magnitudes
	localparam int QUOT_W     = 7;	// quotient never exceeds 90 for a nonzero divisor
	localparam int QIDX_W     = 3;

	localparam int KIND_W     = 3;
	localparam int LEN_W      = 2;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 8;

	typedef struct packed {
		logic              load;
		logic              step;
		logic [QIDX_W-1:0] bit_idx;
	} div_ctrl_t;

endpackage

`default_nettype wire

### rtl/jacr_div.sv
// Restoring divider for the angle: one quotient bit per step, one subtractor.
// Sequenced from the top level through a div_ctrl_t; needs jacr_pkg.
`default_nettype none

module jacr_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire jacr_pkg::div_ctrl_t               ctrl,
	input  wire logic [jacr_pkg::DIVIDEND_W-1:0]   dividend,
	input  wire logic [jacr_pkg::DIVISOR_W-1:0]    divisor,
	output      logic [jacr_pkg::QUOT_W-1:0]       quotient
);
	import jacr_pkg::*;

	localparam int TRIAL_W = DIVISOR_W + QUOT_W;

	logic [DIVIDEND_W-1:0] rem_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [QUOT_W-1:0]     quot_q;
	logic [TRIAL_W-1:0]    trial;
	logic                  fits;

	// The divisor shifted to the weight of the current quotient bit.
	assign trial = {{QUOT_W{1'b0}}, den_q} << ctrl.bit_idx;
	assign fits  = {{(TRIAL_W-DIVIDEND_W){1'b0}}, rem_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			den_q  <= '0;
			quot_q <= '0;
		end else if (ctrl.load) begin
			rem_q  <= dividend;
			den_q  <= divisor;
			quot_q <= '0;
		end else if (ctrl.step && fits) begin
			rem_q                <= rem_q - trial[DIVIDEND_W-1:0];
			quot_q[ctrl.bit_idx] <= 1'b1;
		end
	end

	assign quotient = quot_q;

endmodule

`default_nettype wire

### rtl/joystick_angle_change_reporter_top.sv
// Top level of the joystick angle change reporter: sequencer, change tracking
// and report output register. Needs jacr_pkg and jacr_div.
`default_nettype none

// Usage
// A sample item (four 8-bit readings and two button levels) enters on the
// sample channel when sample_valid and sample_ready are both high. The block
// then works on it alone: it forms magnitudes, quadrant and the scaled
// dividend from the offsets taken at capture, runs the restoring divider
// (one quotient bit a cycle, while a shared compare unit checks the six plain
// values for a change, one per cycle) and then finishes the angle. Reports
// then leave on the report channel, one per cycle while report_ready is high,
// lowest kind first, with last_message set on the final one. An item with no
// change gives no report. The report sits in an output register, so a new
// sample is taken while the final report still waits. A stalled receiver
// holds the report and the block waits with it. Reset sets the registers to
// their defaults (origins 128, dead zone 10, deadband 2) and all last-sent
// values to zero; the configuration port writes one register per cycle, and
// the user must write it only while the block is idle: the block itself does
// not enforce this.
module joystick_angle_change_reporter_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [jacr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire logic [jacr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire logic                               sample_valid,
	output      logic                               sample_ready,
	input  wire logic [7:0]                         joy_y_sample,
	input  wire logic [7:0]                         joy_x_sample,
	input  wire logic [7:0]                         right_slider,
	input  wire logic [7:0]                         left_slider,
	input  wire logic                               left_button,
	input  wire logic                               right_button,
	output      logic                               report_valid,
	input  wire logic                               report_ready,
	output      logic [jacr_pkg::KIND_W-1:0]        message_kind,
	output      logic [jacr_pkg::LEN_W-1:0]         payload_length,
	output      logic [7:0]                         payload_low,
	output      logic [7:0]                         payload_high,
	output      logic                               last_message
);
	import jacr_pkg::*;

	localparam int NUM_KINDS = 7;

	localparam logic [KIND_W-1:0] KIND_JOY_Y    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_JOY_X    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_LEFT_BTN = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RIGHT_BTN = 3'd3;
	localparam logic [KIND_W-1:0] KIND_RIGHT_SLD = 3'd4;
	localparam logic [KIND_W-1:0] KIND_LEFT_SLD = 3'd5;
	localparam logic [KIND_W-1:0] KIND_ANGLE    = 3'd6;

	localparam logic [CFG_ADDR_W-1:0] REG_JOY_X_ORIGIN = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_JOY_Y_ORIGIN = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_DEAD_ZONE    = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND     = 2'd3;

	localparam logic [LEN_W-1:0] LEN_ONE = 2'd1;
	localparam logic [LEN_W-1:0] LEN_TWO = 2'd2;

	localparam logic [8:0] BASE_Q1 = 9'd0;
	localparam logic [8:0] BASE_Q2 = 9'd90;
	localparam logic [8:0] BASE_Q3 = 9'd180;
	localparam logic [8:0] BASE_Q4 = 9'd270;
	localparam logic [6:0] QUAD_SPAN = 7'd90;
	localparam logic [7:0] SIGN_BYTE = 8'hFF;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	// Configuration registers
	logic [7:0] x_origin_q, y_origin_q, dead_zone_q, deadband_q;

	// Sequencer and captured item
	logic [2:0]           state_q;
	logic [QIDX_W-1:0]    cnt_q;
	logic [NUM_KINDS-1:0] flags_q;
	logic [8:0]           y_q, x_q;
	logic [7:0]           rs_q, ls_q;
	logic                 lb_q, rb_q;
	logic [8:0]           base_q;
	logic                 dead_q;
	logic [8:0]           ang_q;

	// Last reported values
	logic [8:0] sent_y_q, sent_x_q, sent_ang_q;
	logic [7:0] sent_rs_q, sent_ls_q;
	logic       sent_lb_q, sent_rb_q;

	// Output register
	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [LEN_W-1:0]  out_len_q;
	logic [7:0]        out_lo_q, out_hi_q;
	logic              out_last_q;

	logic sample_acc;
	assign sample_ready = (state_q == S_IDLE);
	assign sample_acc   = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q  <= 8'd128;
			y_origin_q  <= 8'd128;
			dead_zone_q <= 8'd10;
			deadband_q  <= 8'd2;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_JOY_X_ORIGIN: x_origin_q  <= cfg_wdata;
				REG_JOY_Y_ORIGIN: y_origin_q  <= cfg_wdata;
				REG_DEAD_ZONE:    dead_zone_q <= cfg_wdata;
				REG_DEADBAND:     deadband_q  <= cfg_wdata;
			endcase
		end
	end

	// Magnitudes, quadrant and dividend, formed in the preparation cycle.
	logic [8:0]            x_neg, y_neg;
	logic [7:0]            ax, ay, num_mag;
	logic [DIVIDEND_W-1:0] dividend;
	logic [DIVISOR_W-1:0]  divisor;
	logic [8:0]            base_d;

	assign x_neg    = 9'd0 - x_q;
	assign y_neg    = 9'd0 - y_q;
	assign ax       = x_q[8] ? x_neg[7:0] : x_q[7:0];
	assign ay       = y_q[8] ? y_neg[7:0] : y_q[7:0];
	// Quadrants two and four measure from an axis where X is the numerator.
	assign num_mag  = (x_q[8] ^ y_q[8]) ? ax : ay;
	assign dividend = DIVIDEND_W'(num_mag) * DIVIDEND_W'(QUAD_SPAN);
	assign divisor  = {2'b00, ax} + {2'b00, ay};

	always_comb begin
		unique case ({x_q[8], y_q[8]})
			2'b00: base_d = BASE_Q1;
			2'b10: base_d = BASE_Q2;
			2'b11: base_d = BASE_Q3;
			2'b01: base_d = BASE_Q4;
		endcase
	end

	div_ctrl_t             div_ctrl;
	logic [QUOT_W-1:0]     quot;

	assign div_ctrl.load    = (state_q == S_PREP);
	assign div_ctrl.step    = (state_q == S_DIV);
	assign div_ctrl.bit_idx = QIDX_W'(QUOT_W - 1) - cnt_q;

	jacr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (dividend),
		.divisor  (divisor),
		.quotient (quot)
	);

	// Shared change compare: one plain value per divider cycle.
	logic [8:0] cmp_val, cmp_sent;
	logic [9:0] cmp_diff, cmp_abs;
	logic       cmp_button, changed;

	always_comb begin
		cmp_val    = y_q;
		cmp_sent   = sent_y_q;
		cmp_button = 1'b0;
		unique case (cnt_q)
			KIND_JOY_Y: begin
				cmp_val  = y_q;
				cmp_sent = sent_y_q;
			end
			KIND_JOY_X: begin
				cmp_val  = x_q;
				cmp_sent = sent_x_q;
			end
			KIND_LEFT_BTN: begin
				cmp_val    = {8'd0, lb_q};
				cmp_sent   = {8'd0, sent_lb_q};
				cmp_button = 1'b1;
			end
			KIND_RIGHT_BTN: begin
				cmp_val    = {8'd0, rb_q};
				cmp_sent   = {8'd0, sent_rb_q};
				cmp_button = 1'b1;
			end
			KIND_RIGHT_SLD: begin
				cmp_val  = {1'b0, rs_q};
				cmp_sent = {1'b0, sent_rs_q};
			end
			KIND_LEFT_SLD: begin
				cmp_val  = {1'b0, ls_q};
				cmp_sent = {1'b0, sent_ls_q};
			end
			default: begin
				cmp_val  = y_q;
				cmp_sent = y_q;
			end
		endcase
	end

	assign cmp_diff = {cmp_val[8], cmp_val} - {cmp_sent[8], cmp_sent};
	assign cmp_abs  = cmp_diff[9] ? (10'd0 - cmp_diff) : cmp_diff;
	assign changed  = cmp_button ? (cmp_val != cmp_sent) : (cmp_abs > {2'b00, deadband_q});

	logic [8:0] ang_d;
	assign ang_d = dead_q ? 9'd0 : (base_q + {2'b00, quot});

	// Lowest pending report.
	logic [KIND_W-1:0]    pick;
	logic [NUM_KINDS-1:0] rest;
	logic                 out_free;

	always_comb begin
		pick = '0;
		for (int i = NUM_KINDS - 1; i >= 0; i--) begin
			if (flags_q[i]) pick = KIND_W'(i);
		end
	end

	assign rest     = flags_q & ~(NUM_KINDS'(1) << pick);
	assign out_free = !out_valid_q || report_ready;

	logic emit_load;
	assign emit_load = (state_q == S_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			flags_q    <= '0;
			sent_y_q   <= '0;
			sent_x_q   <= '0;
			sent_lb_q  <= 1'b0;
			sent_rb_q  <= 1'b0;
			sent_rs_q  <= '0;
			sent_ls_q  <= '0;
			sent_ang_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (sample_acc) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					cnt_q   <= '0;
					flags_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q != KIND_ANGLE) begin
						flags_q[cnt_q] <= changed;
					end
					if (changed) begin
						unique case (cnt_q)
							KIND_JOY_Y:     sent_y_q  <= y_q;
							KIND_JOY_X:     sent_x_q  <= x_q;
							KIND_LEFT_BTN:  sent_lb_q <= lb_q;
							KIND_RIGHT_BTN: sent_rb_q <= rb_q;
							KIND_RIGHT_SLD: sent_rs_q <= rs_q;
							KIND_LEFT_SLD:  sent_ls_q <= ls_q;
							default: ;
						endcase
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == QIDX_W'(QUOT_W - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					flags_q[KIND_ANGLE] <= (ang_d != sent_ang_q);
					sent_ang_q          <= ang_d;
					if (flags_q[KIND_LEFT_SLD:KIND_JOY_Y] == '0 && ang_d == sent_ang_q) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						flags_q <= rest;
						if (rest == '0) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Captured item and angle datapath registers.
	always_ff @(posedge clk) begin
		if (sample_acc) begin
			y_q  <= {1'b0, joy_y_sample} - {1'b0, y_origin_q};
			x_q  <= {1'b0, joy_x_sample} - {1'b0, x_origin_q};
			rs_q <= right_slider;
			ls_q <= left_slider;
			lb_q <= left_button;
			rb_q <= right_button;
		end
		if (state_q == S_PREP) begin
			base_q <= base_d;
			dead_q <= !(ax > dead_zone_q || ay > dead_zone_q);
		end
		if (state_q == S_FIN) begin
			ang_q <= ang_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (report_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_kind_q <= pick;
			out_last_q <= (rest == '0);
			unique case (pick)
				KIND_JOY_Y: begin
					out_len_q <= LEN_TWO;
					out_lo_q  <= y_q[7:0];
					out_hi_q  <= y_q[8] ? SIGN_BYTE : 8'd0;
				end
				KIND_JOY_X: begin
					out_len_q <= LEN_TWO;
					out_lo_q  <= x_q[7:0];
					out_hi_q  <= x_q[8] ? SIGN_BYTE : 8'd0;
				end
				KIND_LEFT_BTN: begin
					out_len_q <= LEN_ONE;
					out_lo_q  <= {7'd0, lb_q};
					out_hi_q  <= 8'd0;
				end
				KIND_RIGHT_BTN: begin
					out_len_q <= LEN_ONE;
					out_lo_q  <= {7'd0, rb_q};
					out_hi_q  <= 8'd0;
				end
				KIND_RIGHT_SLD: begin
					out_len_q <= LEN_ONE;
					out_lo_q  <= rs_q;
					out_hi_q  <= 8'd0;
				end
				KIND_LEFT_SLD: begin
					out_len_q <= LEN_ONE;
					out_lo_q  <= ls_q;
					out_hi_q  <= 8'd0;
				end
				default: begin
					out_len_q <= LEN_TWO;
					out_lo_q  <= ang_q[7:0];
					out_hi_q  <= {7'd0, ang_q[8]};
				end
			endcase
		end
	end

	assign report_valid   = out_valid_q;
	assign message_kind   = out_kind_q;
	assign payload_length = out_len_q;
	assign payload_low    = out_lo_q;
	assign payload_high   = out_hi_q;
	assign last_message   = out_last_q;

	// A new item is only taken once every report of the previous one is queued.
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		sample_ready |-> flags_q == '0)
		else $error("sample taken with reports still pending");

	a_emit_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> flags_q != '0)
		else $error("emit state without a pending report");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_load && rest == '0) |=> state_q == S_IDLE)
		else $error("last report loaded but sequencer did not return to idle");

	a_quot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !dead_q) |-> quot <= QUOT_W'(QUAD_SPAN))
		else $error("angle quotient exceeds one quadrant");

endmodule

`default_nettype wire
